// File: hw/rtl/swr_pkg.sv
package swr_pkg;

	localparam int WORD_W         = 64;
	localparam int LEN_W          = 4;
	localparam int BYTE_W         = 8;
	localparam int WORD_BYTES_DEF = 8;
	localparam int CFG_IDX_W      = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEARCH_WORD        = 2'd0,
		CFG_SEARCH_LENGTH      = 2'd1,
		CFG_REPLACEMENT_WORD   = 2'd2,
		CFG_REPLACEMENT_LENGTH = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic sel;
		logic shift;
	} cell_ctrl_t;

endpackage

// File: hw/rtl/swr_window_cell.sv
module swr_window_cell
	import swr_pkg::*;
(
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [BYTE_W-1:0] text_in,
	input  logic [BYTE_W-1:0] next_eff,
	input  logic [BYTE_W-1:0] key,
	output logic [BYTE_W-1:0] eff,
	output logic              eq
);

	logic [BYTE_W-1:0] byte_q;

	assign eff = ctrl.sel ? text_in : byte_q;
	assign eq  = (eff == key);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= next_eff;
		end else if (ctrl.sel) begin
			byte_q <= text_in;
		end
	end

endmodule

// File: hw/rtl/swr_burst_buffer.sv
module swr_burst_buffer
	import swr_pkg::*;
#(
	parameter int MAX_WORD_BYTES = WORD_BYTES_DEF,
	parameter int CW             = $clog2(MAX_WORD_BYTES + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic [BYTE_W*MAX_WORD_BYTES-1:0] load_bytes,
	input  logic [CW-1:0]                    load_cnt,
	input  logic                             load_end,
	input  logic                             take,
	output logic [CW-1:0]                    cnt,
	output logic [BYTE_W-1:0]                head,
	output logic                             last
);

	logic [BYTE_W*MAX_WORD_BYTES-1:0] bytes_q;
	logic [CW-1:0]                    cnt_q;
	logic                             end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			end_q <= 1'b0;
		end else if (load) begin
			cnt_q <= load_cnt;
			end_q <= load_end;
		end else if (take) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= load_bytes;
		end else if (take) begin
			bytes_q <= bytes_q >> BYTE_W;
		end
	end

	assign cnt  = cnt_q;
	assign head = bytes_q[BYTE_W-1:0];
	assign last = end_q && (cnt_q == CW'(1));

endmodule

// File: hw/rtl/stream_word_replace.sv
// Channel   | Direction | Handshake                  | Payload
// text      | in        | text_valid / text_stall    | text_byte, text_end
// result    | out       | result_valid / result_stall| result_byte, result_end
// cfg       | in        | cfg_write                  | cfg_index, cfg_data
//
// Each accepted text byte loads its results into a burst buffer that sends one byte per cycle
// while result_stall is low. A byte that yields k results keeps the input stalled until its
// last result leaves; the next byte is taken in the cycle that the buffer's last pending byte
// leaves, so one result per byte runs at one byte per cycle. arst_n clears the window fill,
// the buffer and the registers. While the buffer holds a byte, a stalled result stalls input.
module stream_word_replace
	import swr_pkg::*;
#(
	parameter int MAX_WORD_BYTES = WORD_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 text_valid,
	output logic                 text_stall,
	input  logic [BYTE_W-1:0]    text_byte,
	input  logic                 text_end,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [BYTE_W-1:0]    result_byte,
	output logic                 result_end
);

	localparam int N  = MAX_WORD_BYTES;
	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N + 1);

	logic [WORD_W-1:0]   search_word_q;
	logic [CW-1:0]       search_len_q;
	logic [WORD_W-1:0]   repl_word_q;
	logic [CW-1:0]       repl_len_q;
	logic [IW-1:0]       fill_q;

	logic [LEN_W-1:0]    len_in;
	logic [CW-1:0]       search_len_in;
	logic [CW-1:0]       repl_len_in;

	logic                text_accept;
	logic                out_take;
	logic [CW-1:0]       buf_cnt;
	logic [IW-1:0]       fill_eff;
	logic [CW-1:0]       fill_ext;
	logic                compare;
	logic                hit;
	logic [N-1:0]        eq;
	logic [N-1:0]        in_word;
	logic [BYTE_W-1:0]   eff [N];
	logic [BYTE_W*N-1:0] eff_flat;
	logic [BYTE_W*N-1:0] burst_bytes;
	logic [CW-1:0]       burst_cnt;
	logic                burst_end;

	assign len_in        = cfg_data[LEN_W-1:0];
	assign search_len_in = (len_in == '0) ? CW'(1) :
		(len_in > LEN_W'(N)) ? CW'(N) : CW'(len_in);
	assign repl_len_in   = (len_in > LEN_W'(N)) ? CW'(N) : CW'(len_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_word_q <= '0;
			search_len_q  <= CW'(1);
			repl_word_q   <= '0;
			repl_len_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SEARCH_WORD:        search_word_q <= cfg_data;
				CFG_SEARCH_LENGTH:      search_len_q  <= search_len_in;
				CFG_REPLACEMENT_WORD:   repl_word_q   <= cfg_data;
				CFG_REPLACEMENT_LENGTH: repl_len_q    <= repl_len_in;
				default: ;
			endcase
		end
	end

	assign out_take    = result_valid && !result_stall;
	assign text_stall  = !((buf_cnt == '0) || ((buf_cnt == CW'(1)) && out_take));
	assign text_accept = text_valid && !text_stall;

	assign fill_eff = (CW'(fill_q) >= search_len_q) ? '0 : fill_q;
	assign fill_ext = CW'(fill_eff);
	assign compare  = ((fill_ext + CW'(1)) == search_len_q);

	for (genvar i = 0; i < N; i++) begin : g_cell
		cell_ctrl_t        ctrl;
		logic [BYTE_W-1:0] next_eff;

		assign ctrl.sel   = text_accept && (fill_eff == IW'(i));
		assign ctrl.shift = text_accept && compare && !hit;
		if (i == N - 1) begin : g_tail
			assign next_eff = '0;
		end else begin : g_body
			assign next_eff = eff[i+1];
		end

		swr_window_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.text_in  (text_byte),
			.next_eff (next_eff),
			.key      (search_word_q[BYTE_W*i +: BYTE_W]),
			.eff      (eff[i]),
			.eq       (eq[i])
		);

		assign in_word[i]                 = (CW'(i) < search_len_q);
		assign eff_flat[BYTE_W*i +: BYTE_W] = eff[i];
	end

	assign hit = &(eq | ~in_word);

	always_comb begin
		burst_bytes = eff_flat;
		burst_cnt   = '0;
		if (compare && hit) begin
			burst_bytes = repl_word_q[BYTE_W*N-1:0];
			burst_cnt   = repl_len_q;
		end else if (compare) begin
			burst_cnt = text_end ? search_len_q : CW'(1);
		end else if (text_end) begin
			burst_cnt = fill_ext + CW'(1);
		end
	end

	assign burst_end = text_end && (burst_cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg_write && (cfg_index == CFG_SEARCH_LENGTH)) begin
			fill_q <= '0;
		end else if (text_accept) begin
			if (text_end || (compare && hit)) begin
				fill_q <= '0;
			end else if (compare) begin
				fill_q <= IW'(search_len_q - CW'(1));
			end else begin
				fill_q <= IW'(fill_ext + CW'(1));
			end
		end
	end

	swr_burst_buffer #(
		.MAX_WORD_BYTES (N),
		.CW             (CW)
	) u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (text_accept),
		.load_bytes (burst_bytes),
		.load_cnt   (burst_cnt),
		.load_end   (burst_end),
		.take       (out_take),
		.cnt        (buf_cnt),
		.head       (result_byte),
		.last       (result_end)
	);

	assign result_valid = (buf_cnt != '0);

endmodule
